/* sv/etc_pkg.sv */
// Package for the escape-time iteration counter.
// Widths, reset values, controller states and the command/status structs.
// No dependencies.
package etc_pkg;

  localparam int Z_W   = 32;  // value format of z and c
  localparam int P_W   = 64;  // full-width product
  localparam int CFG_W = 16;  // max_iterations register
  localparam int OUT_W = 16;  // iterations result field

  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] MAX_ITER_RST = 16'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;  // capture c, z <= c, count <= 0
    logic mul;   // register the three products of z
    logic upd;   // z <= z*z + c, count++
    logic emit;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic stop;  // escaped or limit reached
    logic sat;   // the update about to be taken saturates
  } sts_t;

endpackage

/* sv/etc_if.sv */
// Handshake channel interfaces for the escape-time iteration counter.
// Depends on etc_pkg for field widths.
interface etc_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [etc_pkg::Z_W-1:0] c_real;
  logic signed [etc_pkg::Z_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface etc_out_if;
  logic                       valid;
  logic                       ready;
  logic [etc_pkg::OUT_W-1:0]  iterations;

  modport source (output valid, output iterations, input ready);
  modport sink (input valid, input iterations, output ready);
endinterface

interface etc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [etc_pkg::CFG_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/etc_ctrl.sv */
// Controller for the escape-time iteration counter: sequences load,
// multiply, update and result hand-off. Depends on etc_pkg.
module etc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  etc_pkg::sts_t sts,
  output etc_pkg::cmd_t cmd
);

  etc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= etc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      etc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = etc_pkg::ST_MUL;
        end
      end
      etc_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = etc_pkg::ST_UPD;
      end
      etc_pkg::ST_UPD: begin
        if (sts.stop) begin
          state_nxt = etc_pkg::ST_FIN;
        end else begin
          cmd.upd   = 1'b1;
          // a saturated update ends the point with the count already bumped
          state_nxt = sts.sat ? etc_pkg::ST_FIN : etc_pkg::ST_MUL;
        end
      end
      etc_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = etc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = etc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/etc_datapath.sv */
// Datapath for the escape-time iteration counter: z registers, product
// registers, update with saturation, escape test, count and limit.
// Depends on etc_pkg.
module etc_datapath #(
  parameter int FRAC_BITS  = etc_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = etc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  etc_pkg::cmd_t                   cmd,
  output etc_pkg::sts_t                   sts,
  input  logic                            cfg_we,
  input  logic [etc_pkg::CFG_W-1:0]       cfg_data,
  input  logic signed [etc_pkg::Z_W-1:0]  c_real,
  input  logic signed [etc_pkg::Z_W-1:0]  c_imag,
  output logic [etc_pkg::OUT_W-1:0]       iterations
);

  localparam int Z_W = etc_pkg::Z_W;
  localparam int P_W = etc_pkg::P_W;
  localparam int LIM_W = 33;
  localparam logic [LIM_W-1:0] CMAX = (LIM_W'(1) << COUNT_BITS) - LIM_W'(1);
  localparam int  ESC_SH = 2 * FRAC_BITS + 2;
  localparam bit  ESC_EN = (ESC_SH < P_W);
  localparam logic [P_W-1:0] ESC_THR = P_W'(1) << (ESC_EN ? ESC_SH : 0);

  logic [etc_pkg::CFG_W-1:0]   max_iter_r;
  logic signed [Z_W-1:0]       c_re_r, c_im_r;
  logic signed [Z_W-1:0]       z_re_r, z_im_r, z_re_nxt, z_im_nxt;
  logic signed [P_W-1:0]       rr_r, ii_r, ri_r;
  logic [COUNT_BITS-1:0]       count_r;
  logic [etc_pkg::OUT_W-1:0]   iterations_r;

  logic [LIM_W-1:0]      limit, count_ext;
  logic signed [P_W-1:0] rr_nxt, ii_nxt, ri_nxt;
  logic signed [P_W-1:0] dsq, new_re, new_im;
  logic [P_W-1:0]        mag_sum;
  logic                  sat_re, sat_im, escaped;
  logic [31:0]           count_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= etc_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      max_iter_r <= cfg_data;
    end
  end

  // one multiplier per product, registered before use
  assign rr_nxt = z_re_r * z_re_r;
  assign ii_nxt = z_im_r * z_im_r;
  assign ri_nxt = z_re_r * z_im_r;

  // arithmetic shift is the floor; 2*re*im uses one fraction bit less
  assign dsq    = rr_r - ii_r;
  assign new_re = (dsq >>> FRAC_BITS) + P_W'(c_re_r);
  assign new_im = (ri_r >>> (FRAC_BITS - 1)) + P_W'(c_im_r);

  assign sat_re = (new_re[P_W-1:Z_W-1] != {(P_W-Z_W+1){1'b0}}) &&
                  (new_re[P_W-1:Z_W-1] != {(P_W-Z_W+1){1'b1}});
  assign sat_im = (new_im[P_W-1:Z_W-1] != {(P_W-Z_W+1){1'b0}}) &&
                  (new_im[P_W-1:Z_W-1] != {(P_W-Z_W+1){1'b1}});

  always_comb begin
    if (sat_re) begin
      z_re_nxt = new_re[P_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
    end else begin
      z_re_nxt = new_re[Z_W-1:0];
    end
    if (sat_im) begin
      z_im_nxt = new_im[P_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
    end else begin
      z_im_nxt = new_im[Z_W-1:0];
    end
  end

  // squares of the current z double as the escape test of the last update
  assign mag_sum = rr_r + ii_r;
  assign escaped = ESC_EN && (mag_sum > ESC_THR);

  assign limit     = (LIM_W'(max_iter_r) > CMAX) ? CMAX : LIM_W'(max_iter_r);
  assign count_ext = LIM_W'(count_r);

  assign sts.stop = ((count_r != '0) && escaped) || (count_ext >= limit);
  assign sts.sat  = sat_re || sat_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_re_r  <= '0;
      z_im_r  <= '0;
      count_r <= '0;
    end else if (cmd.load) begin
      z_re_r  <= c_real;
      z_im_r  <= c_imag;
      count_r <= '0;
    end else if (cmd.upd) begin
      z_re_r  <= z_re_nxt;
      z_im_r  <= z_im_nxt;
      count_r <= count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re_r <= c_real;
      c_im_r <= c_imag;
    end
    if (cmd.mul) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      ri_r <= ri_nxt;
    end
  end

  assign count_w = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      iterations_r <= count_w[etc_pkg::OUT_W-1:0];
    end
  end

  assign iterations = iterations_r;

endmodule

/* sv/escape_time_iteration_counter.sv */
// Top level of the escape-time iteration counter (Mandelbrot point test).
// Depends on etc_pkg, etc_if, etc_ctrl and etc_datapath.
//
//   channel   | dir | payload                         | transaction
//   in_chan   | in  | c_real, c_imag (Q4.28 signed)   | valid && ready
//   out_chan  | out | iterations (16 bit unsigned)    | valid && ready
//   cfg_chan  | in  | data -> max_iterations          | valid && ready (ready tied high)
//
// Accept loads c; each iteration then registers the products and then
// updates z; after the last update a final multiply and test follow,
// and then the hand-off. A saturating update ends the point at once,
// with no further test. One point is worked at a time; the next is
// accepted while a result still waits in the output register. Synchronous
// active-low reset sets max_iterations to 1000 and clears z and the count.
module escape_time_iteration_counter #(
  parameter int FRAC_BITS  = etc_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = etc_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  etc_in_if.sink    in_chan,
  etc_out_if.source out_chan,
  etc_cfg_if.sink   cfg_chan
);

  etc_pkg::cmd_t cmd;
  etc_pkg::sts_t sts;
  logic          cfg_we;

  assign cfg_chan.ready = 1'b1;
  assign cfg_we         = cfg_chan.valid && cfg_chan.ready;

  etc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  etc_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_chan.data),
    .c_real     (in_chan.c_real),
    .c_imag     (in_chan.c_imag),
    .iterations (out_chan.iterations)
  );

  // an accepted point keeps the input closed while it is worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input accepted again straight after a transaction");

  // a result hand-off always presents a valid result next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_chan.valid)
    else $error("result loaded but not presented");

  // a saturating update ends the point: no further multiply, no new input
  a_sat_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && sts.sat |=> !cmd.mul && !in_chan.ready)
    else $error("iteration continued after saturation");

endmodule

/* tb/tb_escape_time_iteration_counter.sv */
`timescale 1ns / 1ps
// Testbench for escape_time_iteration_counter: directed and random Mandelbrot points,
// each iteration count predicted in the bench and checked in order of arrival.
// Depends on etc_pkg, etc_if and the RTL of the block.
module tb_escape_time_iteration_counter;

  localparam int Z_W   = etc_pkg::Z_W;
  localparam int OUT_W = etc_pkg::OUT_W;
  localparam int CFG_W = etc_pkg::CFG_W;
  localparam logic [CFG_W-1:0] MAX_ITER_RST = etc_pkg::MAX_ITER_RST;

  localparam int FRAC          = etc_pkg::FRAC_BITS_DEF;
  localparam int CNT_BITS      = etc_pkg::COUNT_BITS_DEF;
  localparam int ESC_SHIFT     = 2 * FRAC + 2;
  localparam int ONE           = 1 << FRAC;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int BATCH         = 50;

  localparam logic signed [Z_W-1:0] Z_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Z_W-1:0] Z_MIN = 32'sh8000_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic signed [Z_W-1:0] c_re;
    logic signed [Z_W-1:0] c_im;
    logic [OUT_W-1:0]      iterations;
  } point_count_t;

  logic clk = 1'b0;
  logic rst_n;

  etc_in_if  in_if ();
  etc_out_if out_if ();
  etc_cfg_if cfg_if ();

  escape_time_iteration_counter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  point_count_t     pending_counts[$];
  logic [CFG_W-1:0] iter_limit = MAX_ITER_RST;
  int unsigned      in_idle_pct  = 0;
  int unsigned      out_idle_pct = 0;
  int unsigned      errors       = 0;
  int unsigned      points_sent  = 0;
  int unsigned      counts_seen  = 0;
  int unsigned      limit_writes = 0;
  int unsigned      escaped_pts  = 0;
  longint unsigned  cycles       = 0;

  // Escape-time count of one point for the current limit
  function automatic logic [OUT_W-1:0] escape_count(logic signed [Z_W-1:0] c_re,
                                                    logic signed [Z_W-1:0] c_im,
                                                    logic [CFG_W-1:0] lim);
    longint          zr, zi, nr, ni;
    longint unsigned mr, mi, radius_sq, cap, n;
    bit              sat;
    cap = (64'd1 << CNT_BITS) - 1;
    if (lim < cap) cap = lim;
    zr = c_re;
    zi = c_im;
    n  = 0;
    while (n < cap) begin
      nr  = ((zr * zr - zi * zi) >>> FRAC) + c_re;
      ni  = ((zr * zi) >>> (FRAC - 1)) + c_im;
      sat = 1'b0;
      if (nr > SAT_HI) begin nr = SAT_HI; sat = 1'b1; end
      if (nr < SAT_LO) begin nr = SAT_LO; sat = 1'b1; end
      if (ni > SAT_HI) begin ni = SAT_HI; sat = 1'b1; end
      if (ni < SAT_LO) begin ni = SAT_LO; sat = 1'b1; end
      zr = nr;
      zi = ni;
      n++;
      mr = (zr < 0) ? -zr : zr;
      mi = (zi < 0) ? -zi : zi;
      radius_sq = mr * mr + mi * mi;
      // threshold 4.0 at doubled fraction width; unreachable if it overflows 64 bits
      if (sat || (ESC_SHIFT < 64 && radius_sq > (64'd1 << ESC_SHIFT))) break;
    end
    return n[OUT_W-1:0];
  endfunction

  // Output ready: stalls at the configured rate
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    point_count_t exp_pt;
    if (rst_n && out_if.valid && out_if.ready) begin
      counts_seen++;
      if (pending_counts.size() == 0) begin
        $error("iterations: result %0d with no point outstanding", out_if.iterations);
        errors++;
      end else begin
        exp_pt = pending_counts.pop_front();
        if (out_if.iterations !== exp_pt.iterations) begin
          $error("iterations mismatch for c=(%0d,%0d): expected %0d, actual %0d",
                 exp_pt.c_re, exp_pt.c_im, exp_pt.iterations, out_if.iterations);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One point transaction, with a random gap in front of it
  task automatic send_point(input logic signed [Z_W-1:0] c_re,
                            input logic signed [Z_W-1:0] c_im);
    point_count_t pt;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.c_real <= c_re;
    in_if.c_imag <= c_im;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pt.c_re       = c_re;
    pt.c_im       = c_im;
    pt.iterations = escape_count(c_re, c_im, iter_limit);
    if (pt.iterations < iter_limit) escaped_pts++;
    pending_counts.push_back(pt);
    points_sent++;
  endtask

  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] lim);
    drain_block();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= lim;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    iter_limit = lim;
    limit_writes++;
  endtask

  // Point mostly inside the window around the set, else any 32-bit value
  task automatic pick_point(output logic signed [Z_W-1:0] c_re,
                            output logic signed [Z_W-1:0] c_im);
    if ($urandom_range(0, 99) < 85) begin
      c_re = int'($urandom_range(0, 3 * ONE)) - (2 * ONE + ONE / 4);
      c_im = int'($urandom_range(0, 3 * ONE)) - (ONE + ONE / 2);
    end else begin
      c_re = $urandom;
      c_im = $urandom;
    end
  endtask

  // Reset limit: bounded points, the -2 equality edge and an escaping one
  task automatic test_default_limit();
    send_point(0, 0);
    send_point(-2 * ONE, 0);
    send_point(ONE / 4, 0);
    send_point(0, ONE);
    send_point(ONE, ONE);
  endtask

  task automatic test_field_extremes();
    send_point(Z_MAX, Z_MAX);
    send_point(Z_MIN, Z_MIN);
    send_point(Z_MIN, Z_MAX);
    send_point(Z_MAX, Z_MIN);
    send_point(0, Z_MIN);
    send_point(Z_MIN, 0);
    send_point(0, Z_MAX);
    send_point(Z_MAX, 0);
    send_point(1, 0);
    send_point(-1, -1);
  endtask

  task automatic test_zero_limit();
    write_limit('0);
    send_point(0, 0);
    send_point(Z_MAX, Z_MIN);
    send_point(ONE, ONE);
  endtask

  task automatic test_unit_limit();
    write_limit(16'd1);
    send_point(0, 0);
    send_point(Z_MIN, Z_MIN);
    send_point(2 * ONE + 1, 0);
  endtask

  // Widest limit: one full-length bounded point, the rest escape early
  task automatic test_full_limit();
    write_limit('1);
    send_point(0, 0);
    send_point(ONE / 2, ONE / 2);
    send_point(Z_MAX, 0);
  endtask

  task automatic test_random_points(input int unsigned in_pct, input int unsigned out_pct,
                                    input int unsigned n_points);
    logic [CFG_W-1:0]      limits[8] = '{16'd1000, 16'd200, 16'd64, 16'd16,
                                         16'd5, 16'd2, 16'd1, 16'd0};
    logic signed [Z_W-1:0] c_re, c_im;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int unsigned k = 0; k < n_points; k++) begin
      if (k % BATCH == 0) write_limit(limits[$urandom_range(0, 7)]);
      pick_point(c_re, c_im);
      send_point(c_re, c_im);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.c_real <= '0;
    in_if.c_imag <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= MAX_ITER_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_limit();
    test_field_extremes();
    test_zero_limit();
    test_unit_limit();
    test_full_limit();
    test_random_points(24, 68, 200);
    test_random_points(68, 24, 200);
    test_random_points(0, 0, 200);

    drain_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d points sent, %0d counts checked, %0d escaped before the limit",
             points_sent, counts_seen, escaped_pts);
    $display("Summary: %0d limit writes incl. 0 and 65535, %0d errors", limit_writes, errors);
    if (errors == 0 && pending_counts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
